// ----- rtl/ple_pkg.sv -----
// Shared types and constants for the positional list engine.
package ple_pkg;

  // Default number of list entries
  localparam int unsigned CAPACITY_DEF = 16;

  // Payload field widths
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned FIDX_W   = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ECNT_W   = 5;

  // Operation codes carried in the kind field
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 3'd0,
    KIND_MODIFY = 3'd1,
    KIND_DELETE = 3'd2,
    KIND_READ   = 3'd3,
    KIND_SEARCH = 3'd4
  } kind_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Update applied by every cell of the chain
  typedef enum logic [1:0] {
    CO_NONE   = 2'd0,
    CO_INSERT = 2'd1,
    CO_DELETE = 2'd2,
    CO_MODIFY = 2'd3
  } cell_op_e;

  // Broadcast control word for the cell chain
  typedef struct packed {
    cell_op_e               op;
    logic signed [VAL_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ----- rtl/ple_in_if.sv -----
// Request channel of the positional list engine.
interface ple_in_if;
  logic                               valid;
  logic                               ready;
  logic [ple_pkg::KIND_W-1:0]         kind;
  logic [ple_pkg::POS_W-1:0]          position;
  logic signed [ple_pkg::VAL_W-1:0]   value;

  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface

// ----- rtl/ple_out_if.sv -----
// Result channel of the positional list engine.
interface ple_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ple_pkg::VAL_W-1:0]   read_value;
  logic [ple_pkg::FIDX_W-1:0]         found_index;
  logic [ple_pkg::STATUS_W-1:0]       status;
  logic [ple_pkg::ECNT_W-1:0]         entry_count;
  logic                               is_empty;

  modport source (output valid, read_value, found_index, status, entry_count, is_empty,
                  input ready);
  modport sink   (input valid, read_value, found_index, status, entry_count, is_empty,
                  output ready);
endinterface

// ----- rtl/ple_cell.sv -----
// One list slot: holds an entry, shifts with its neighbors, compares for search.
module ple_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned AW  = 8
) (
  input  logic                              clk_i,
  input  ple_pkg::cell_ctrl_t               ctrl_i,
  input  logic [AW-1:0]                     pos_i,
  input  logic [AW-1:0]                     count_i,
  input  logic signed [ple_pkg::VAL_W-1:0]  prev_i,
  input  logic signed [ple_pkg::VAL_W-1:0]  next_i,
  output logic signed [ple_pkg::VAL_W-1:0]  entry_o,
  output logic                              match_o
);

  localparam logic [AW-1:0] IDX_W = AW'(IDX);

  logic signed [ple_pkg::VAL_W-1:0] entry_q, entry_d;

  // Next entry: take the new word, a neighbor's word, or hold
  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      ple_pkg::CO_INSERT: begin
        if (IDX_W == pos_i) begin
          entry_d = ctrl_i.value;
        end else if (IDX_W > pos_i) begin
          entry_d = prev_i;
        end
      end
      ple_pkg::CO_DELETE: begin
        if (IDX_W >= pos_i) begin
          entry_d = next_i;
        end
      end
      ple_pkg::CO_MODIFY: begin
        if (IDX_W == pos_i) begin
          entry_d = ctrl_i.value;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  // Payload storage, no reset
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign match_o = (IDX_W < count_i) && (entry_q == ctrl_i.value);

endmodule

// ----- rtl/positional_list_engine_unit.sv -----
// Top level of the positional list engine: request decode, cell chain, result register.
//
// Bounded ordered list of signed 32-bit words held in a chain of CAPACITY cells.
// Request channel in_i carries kind, position and value; result channel out_o
// returns read_value, found_index, status, entry_count and is_empty, exactly one
// result word per request word.
// Every operation (insert, modify, delete, read, search) completes in the cycle
// it is accepted: the cells shift or overwrite in parallel and the result is
// captured in the output register, visible on out_o in the cycle after acceptance.
// Throughput is one request per cycle while out_o.ready stays high; the critical
// path is the first-match priority encoder across all cells and the read multiplexer.
// A request is taken whenever the output register is empty or being drained, so
// when the receiver stalls, one result waits in the register and in_i.ready drops.
// Reset clears the entry count and the output valid flag; entry storage is not
// cleared and is only ever read below the count.
// Out-of-range positions, inserts into a full list and failed searches leave
// the list unchanged and report a status code.
module positional_list_engine_unit #(
  parameter int unsigned CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ple_in_if.sink     in_i,
  ple_out_if.source  out_o
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = CW + ple_pkg::POS_W;
  localparam int unsigned FW = IW + ple_pkg::FIDX_W;
  localparam int unsigned EW = CW + ple_pkg::ECNT_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [CW-1:0]          count_q, count_d;
  logic                   out_valid_q;
  logic                   accept;
  logic [AW-1:0]          pos_w, cnt_w;
  ple_pkg::cell_ctrl_t    ctrl;
  ple_pkg::status_e       status;
  logic signed [ple_pkg::VAL_W-1:0] rd_value;
  logic [IW-1:0]          hit_idx;
  logic                   hit;

  logic signed [ple_pkg::VAL_W-1:0] entries [CAPACITY];
  logic [CAPACITY-1:0]    match;

  logic signed [ple_pkg::VAL_W-1:0] rd_q;
  logic [ple_pkg::FIDX_W-1:0]       fidx_q;
  ple_pkg::status_e                 status_q;
  logic [ple_pkg::ECNT_W-1:0]       ecnt_q;
  logic                             empty_q;
  logic [FW-1:0]                    fidx_w;
  logic [EW-1:0]                    ecnt_w;

  // Handshake: take a word when the result register is free or draining
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign pos_w = AW'(in_i.position);
  assign cnt_w = AW'(count_q);

  // First matching cell, lowest index wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end

  // Decode the request into status, cell update and new count
  always_comb begin
    status   = ple_pkg::ST_OK;
    ctrl.op  = ple_pkg::CO_NONE;
    ctrl.value = in_i.value;
    count_d  = count_q;
    rd_value = '0;
    case (in_i.kind)
      ple_pkg::KIND_INSERT: begin
        if (pos_w > cnt_w) begin
          status = ple_pkg::ST_RANGE;
        end else if (count_q == CAP_C) begin
          status = ple_pkg::ST_FULL;
        end else begin
          ctrl.op = ple_pkg::CO_INSERT;
          count_d = count_q + CW'(1);
        end
      end
      ple_pkg::KIND_MODIFY: begin
        if (pos_w >= cnt_w) begin
          status = ple_pkg::ST_RANGE;
        end else begin
          ctrl.op = ple_pkg::CO_MODIFY;
        end
      end
      ple_pkg::KIND_DELETE: begin
        if (pos_w >= cnt_w) begin
          status = ple_pkg::ST_RANGE;
        end else begin
          ctrl.op = ple_pkg::CO_DELETE;
          count_d = count_q - CW'(1);
        end
      end
      ple_pkg::KIND_READ: begin
        if (pos_w >= cnt_w) begin
          status = ple_pkg::ST_RANGE;
        end else begin
          rd_value = entries[pos_w[IW-1:0]];
        end
      end
      ple_pkg::KIND_SEARCH: begin
        if (!hit) begin
          status = ple_pkg::ST_NOTFOUND;
        end
      end
      default: begin
        status = ple_pkg::ST_OK;
      end
    endcase
    if (!accept) begin
      ctrl.op = ple_pkg::CO_NONE;
      count_d = count_q;
    end
  end

  // Cell chain: each cell sees its neighbors; zero below cell 0, itself above the last
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [ple_pkg::VAL_W-1:0] prev, next;
    if (g == 0) begin : g_first
      assign prev = '0;
    end else begin : g_mid_lo
      assign prev = entries[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next = entries[g];
    end else begin : g_mid_hi
      assign next = entries[g+1];
    end
    ple_cell #(
      .IDX (g),
      .AW  (AW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pos_i   (pos_w),
      .count_i (cnt_w),
      .prev_i  (prev),
      .next_i  (next),
      .entry_o (entries[g]),
      .match_o (match[g])
    );
  end

  // Result fields trimmed to port widths
  assign fidx_w = (in_i.kind == ple_pkg::KIND_SEARCH && hit) ? FW'(hit_idx) : '0;
  assign ecnt_w = EW'(count_d);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q     <= rd_value;
      fidx_q   <= fidx_w[ple_pkg::FIDX_W-1:0];
      status_q <= status;
      ecnt_q   <= ecnt_w[ple_pkg::ECNT_W-1:0];
      empty_q  <= (count_d == '0);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.read_value  = rd_q;
  assign out_o.found_index = fidx_q;
  assign out_o.status      = status_q;
  assign out_o.entry_count = ecnt_q;
  assign out_o.is_empty    = empty_q;

endmodule

// ----- test/ple_list_checker.sv -----
// Scoreboard for the positional list engine: shadow list, expected results and comparison.
`timescale 1ns / 1ps

module ple_list_checker
  import ple_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ple_in_if           in_mon,
  ple_out_if          out_mon,
  output int unsigned fails_o,
  output int unsigned pending_o
);

  // One result word as the block returns it
  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [FIDX_W-1:0]       found_index;
    logic [STATUS_W-1:0]     status;
    logic [ECNT_W-1:0]       entry_count;
    logic                    is_empty;
  } list_result_t;

  // Shadow copy of the list
  logic signed [VAL_W-1:0] list_q [CAPACITY_DEF];
  int                      list_len = 0;

  list_result_t            result_q [$];
  int unsigned             fail_cnt = 0;

  // Apply one request word to the shadow list and return the result it should give
  function automatic list_result_t step_list(logic [KIND_W-1:0] kind,
                                             logic [POS_W-1:0] pos,
                                             logic signed [VAL_W-1:0] val);
    list_result_t r;
    int           p;
    bit           hit;
    r   = '0;
    p   = int'(pos);
    hit = 1'b0;
    r.status = ST_OK;
    case (kind)
      KIND_INSERT: begin
        if (p > list_len) begin
          r.status = ST_RANGE;
        end else if (list_len >= int'(CAPACITY_DEF)) begin
          r.status = ST_FULL;
        end else begin
          for (int i = list_len; i > p; i--) list_q[i] = list_q[i-1];
          list_q[p] = val;
          list_len++;
        end
      end
      KIND_MODIFY: begin
        if (p >= list_len) r.status = ST_RANGE;
        else list_q[p] = val;
      end
      KIND_DELETE: begin
        if (p >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = p; i + 1 < list_len; i++) list_q[i] = list_q[i+1];
          list_len--;
        end
      end
      KIND_READ: begin
        if (p >= list_len) r.status = ST_RANGE;
        else r.read_value = list_q[p];
      end
      KIND_SEARCH: begin
        r.status = ST_NOTFOUND;
        // first match wins
        for (int i = 0; i < list_len; i++) begin
          if (!hit && list_q[i] == val) begin
            hit           = 1'b1;
            r.found_index = FIDX_W'(i);
            r.status      = ST_OK;
          end
        end
      end
      default: ;  // unused codes leave the list alone
    endcase
    r.entry_count = ECNT_W'(list_len);
    r.is_empty    = (list_len == 0);
    return r;
  endfunction

  // Track requests and check results on every accepted word
  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    list_result_t got;
    if (!rst_ni) begin
      list_len = 0;
      result_q.delete();
      pending_o <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        result_q.push_back(step_list(in_mon.kind, in_mon.position, in_mon.value));
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.read_value, out_mon.found_index, out_mon.status,
               out_mon.entry_count, out_mon.is_empty};
        if (result_q.size() == 0) begin
          if (fail_cnt < 10)
            $display("[%0t] result word with no request outstanding", $time);
          fail_cnt++;
        end else begin
          want = result_q.pop_front();
          if (got.read_value !== want.read_value || got.found_index !== want.found_index ||
              got.status !== want.status || got.entry_count !== want.entry_count ||
              got.is_empty !== want.is_empty) begin
            if (fail_cnt < 10)
              $display("[%0t] mismatch exp rd=%0d idx=%0d st=%0d cnt=%0d emp=%0d",
                       $time, want.read_value, want.found_index, want.status,
                       want.entry_count, want.is_empty,
                       " got rd=%0d idx=%0d st=%0d cnt=%0d emp=%0d",
                       got.read_value, got.found_index, got.status,
                       got.entry_count, got.is_empty);
            fail_cnt++;
          end
        end
      end
      pending_o <= result_q.size();
    end
    fails_o <= fail_cnt;
  end

endmodule

// ----- test/tb.sv -----
// Testbench top for the positional list engine: clock, reset, request and result drivers.
`timescale 1ns / 1ps

module tb;
  import ple_pkg::*;

  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int RANDOM_ITEMS   = 1650;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES    = 10;
  localparam int POOL_SIZE      = 6;

  localparam logic [KIND_W-1:0]       KIND_UNUSED_FIRST = 3'd5;
  localparam logic [KIND_W-1:0]       KIND_UNUSED_LAST  = 3'd7;
  localparam logic [POS_W-1:0]        POS_TOP           = '1;
  localparam logic signed [VAL_W-1:0] VAL_MIN           = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX           = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] VAL_NEG_ONE       = -32'sd1;

  // Shape of a stretch of random traffic
  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_CHURN, MIX_NOISE} mix_e;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fails;
  int unsigned pending;
  int          cycle_cnt = 0;

  bit          no_gap;
  bit          rx_hold_req;
  bit          rx_on;
  int          rx_left;

  logic signed [VAL_W-1:0] val_pool [POOL_SIZE];

  ple_in_if  req_if ();
  ple_out_if rsp_if ();

  positional_list_engine_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  ple_list_checker chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (req_if),
    .out_mon   (rsp_if),
    .fails_o   (fails),
    .pending_o (pending)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: alternating ready/stall stretches, one long hold on request
  initial begin
    rsp_if.ready = 1'b0;
    rx_on        = 1'b0;
    rx_left      = 0;
    forever begin
      @(posedge clk_i);
      if (rx_left == 0) begin
        rx_on = !rx_on;
        if (!rx_on && rx_hold_req) begin
          rx_left     = RX_HOLD_CYCLES;
          rx_hold_req = 1'b0;
        end else if (rx_on) begin
          rx_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 12);
        end else begin
          rx_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
        end
      end
      rsp_if.ready <= rx_on;
      rx_left--;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gap || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind(mix_e mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        if (r < 70) return KIND_INSERT;
        if (r < 78) return KIND_SEARCH;
        if (r < 86) return KIND_READ;
        if (r < 93) return KIND_MODIFY;
        return KIND_DELETE;
      end
      MIX_SHRINK: begin
        if (r < 65) return KIND_DELETE;
        if (r < 75) return KIND_INSERT;
        if (r < 85) return KIND_READ;
        if (r < 93) return KIND_SEARCH;
        return KIND_MODIFY;
      end
      MIX_CHURN: return KIND_W'($urandom_range(KIND_INSERT, KIND_SEARCH));
      default: begin
        if (r < 40) return KIND_W'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
        return KIND_W'($urandom_range(KIND_INSERT, KIND_SEARCH));
      end
    endcase
  endfunction

  // Mostly near the front so operations land in range; noise reaches the top bit
  function automatic logic [POS_W-1:0] pick_pos(mix_e mix);
    if (mix == MIX_NOISE) return POS_W'($urandom_range(0, POS_TOP));
    if ($urandom_range(0, 1) == 0) return POS_W'($urandom_range(0, 2));
    return POS_W'($urandom_range(0, CAPACITY_DEF));
  endfunction

  // Pool values repeat so searches hit and duplicates appear
  function automatic logic signed [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 55) return val_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom();
  endfunction

  // Offer one request word and return at the edge where it is taken
  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                           input logic signed [VAL_W-1:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.kind     <= kind;
    req_if.position <= pos;
    req_if.value    <= val;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Stop offering and wait until every outstanding result is back
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int   sent;
    int   span;
    mix_e mix;
    bit   pressure_done;

    req_if.valid    = 1'b0;
    req_if.kind     = '0;
    req_if.position = '0;
    req_if.value    = '0;
    rst_ni          = 1'b0;
    no_gap          = 1'b0;
    rx_hold_req     = 1'b0;
    pressure_done   = 1'b0;
    sent            = 0;

    val_pool[0] = VAL_MIN;
    val_pool[1] = VAL_MAX;
    val_pool[2] = '0;
    val_pool[3] = VAL_NEG_ONE;
    val_pool[4] = $urandom();
    val_pool[5] = $urandom();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty list, ends and middle, duplicates, unused codes
    send_word(KIND_READ,   '0, '0);
    send_word(KIND_DELETE, '0, '0);
    send_word(KIND_MODIFY, '0, VAL_MAX);
    send_word(KIND_SEARCH, '0, '0);
    send_word(KIND_INSERT, 5'd1, VAL_MAX);
    send_word(KIND_INSERT, '0, VAL_MIN);
    send_word(KIND_INSERT, 5'd1, VAL_MAX);
    send_word(KIND_INSERT, 5'd1, 32'sh1234_5678);
    send_word(KIND_INSERT, '0, VAL_NEG_ONE);
    send_word(KIND_READ,   5'd3, '0);
    send_word(KIND_READ,   POS_TOP, '0);
    send_word(KIND_MODIFY, 5'd2, VAL_MAX);
    send_word(KIND_SEARCH, 5'd9, VAL_MAX);
    send_word(KIND_SEARCH, '0, 32'sd5);
    send_word(KIND_DELETE, '0, '0);
    send_word(KIND_DELETE, 5'd2, '0);
    send_word(KIND_DELETE, 5'd3, '0);
    send_word(KIND_UNUSED_FIRST, POS_TOP, VAL_NEG_ONE);
    send_word(KIND_W'(KIND_UNUSED_FIRST + 1), '0, VAL_MIN);
    send_word(KIND_UNUSED_LAST, POS_TOP, VAL_NEG_ONE);
    send_word(KIND_INSERT, POS_TOP, VAL_NEG_ONE);
    send_word(KIND_READ,   '0, '0);

    // Random stretches that grow, shrink, churn or scramble the list
    while (sent < RANDOM_ITEMS) begin
      mix    = mix_e'($urandom_range(MIX_GROW, MIX_NOISE));
      span   = $urandom_range(30, 80);
      no_gap = ($urandom_range(0, 3) == 0);
      if (!pressure_done && sent >= RANDOM_ITEMS / 2) begin
        // quiet the block, then back-pressure it while requests keep coming
        drain();
        rx_hold_req   = 1'b1;
        no_gap        = 1'b1;
        mix           = MIX_GROW;
        pressure_done = 1'b1;
      end
      for (int n = 0; n < span; n++) begin
        send_word(pick_kind(mix), pick_pos(mix), pick_value());
        sent++;
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fails == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
